[src/assert_macros.svh]
// ============================================================================
// assert_macros.svh
// Assertion helpers shared by the RTL; they compile away under SYNTHESIS.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked at every clock edge once reset is released.
`define QN_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Checked at every clock edge, reset included.
`define QN_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define QN_ASSERT(name, clk, rst_n, prop)
`define QN_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

[src/qnlerp_pkg.sv]
// ============================================================================
// qnlerp_pkg
// Widths, constants and stage record types of the quaternion nlerp unit.
// ============================================================================
package qnlerp_pkg;

  localparam int CompW   = 16;  // Q2.14 component
  localparam int WeightW = 17;  // Q0.16 weight, one inclusive
  localparam int ProdW   = 32;  // component product
  localparam int BlendW  = 33;  // one blend term
  localparam int MagW    = 29;  // reduced blend magnitude
  localparam int SqW     = 57;  // squared magnitude
  localparam int SumW    = 59;  // sum of squares
  localparam int RootW   = 30;  // length
  localparam int SqIter  = 30;  // root iterations, two radicand bits each
  localparam int NumW    = 44;  // dividend of the normalize step
  localparam int DenW    = 31;  // divisor, twice the length
  localparam int QuotW   = 15;  // quotient magnitude
  localparam int DivIter = 15;  // one quotient bit per stage

  localparam logic [WeightW-1:0]       WeightOne = 17'd65536;
  localparam logic [RootW-1:0]         DegenLen  = 30'd13422;
  localparam logic signed [CompW-1:0]  QuatOne   = 16'sd16384;
  localparam logic signed [CompW-1:0]  QuatZero  = 16'sd0;

  typedef logic signed [CompW-1:0] comp_t;

  typedef struct packed {
    logic [3:0][MagW-1:0] mag;
    logic [3:0]           neg;
  } lanes_t;

  typedef struct packed {
    logic [SumW:0] rem;
    logic [SumW:0] root;
    lanes_t        lanes;
  } sqrt_stage_t;

  typedef struct packed {
    logic [3:0][NumW-1:0]  rem;
    logic [3:0][QuotW-1:0] quo;
    logic [DenW-1:0]       den;
    logic [3:0]            neg;
    logic                  degen;
  } div_stage_t;

endpackage

[src/qnlerp_if.sv]
// ============================================================================
// qnlerp_if
// Valid/ready channels of the quaternion nlerp unit.
// ============================================================================
interface qnlerp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] first_x;
  logic signed [15:0] first_y;
  logic signed [15:0] first_z;
  logic signed [15:0] first_w;
  logic signed [15:0] second_x;
  logic signed [15:0] second_y;
  logic signed [15:0] second_z;
  logic signed [15:0] second_w;
  logic [16:0]        blend_weight;

  modport source (output valid, first_x, first_y, first_z, first_w,
                  second_x, second_y, second_z, second_w, blend_weight,
                  input ready);
  modport sink (input valid, first_x, first_y, first_z, first_w,
                second_x, second_y, second_z, second_w, blend_weight,
                output ready);
endinterface

interface qnlerp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  logic signed [15:0] out_w;
  logic               degenerate;

  modport source (output valid, out_x, out_y, out_z, out_w, degenerate,
                  input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, degenerate,
                output ready);
endinterface

[src/quaternion_nlerp_unit.sv]
// ============================================================================
// quaternion_nlerp_unit
// Shortest-path normalized blend of two Q2.14 quaternions.
// ============================================================================
// Input channel in_i carries two quaternions and a Q0.16 weight (values
// above one saturate); output channel out_o carries the unit-length blend
// and a degenerate flag that marks an identity result for a near-zero length.
// Both are valid/ready; a transfer happens when valid and ready are high.
// One item is taken every cycle while the receiver does not stall.
// The pipeline: products, dot sign, blend and round, square, sum, 30 root
// stages (two radicand bits each), divisor setup, 15 restoring divide
// stages (one quotient bit each), output register. The root and divide
// chains set the depth.
// The whole pipeline advances when the output register is empty or taken;
// while the receiver stalls, in_i.ready is low and every stage holds.
// Reset clears all valid bits; data registers are not reset.
// ============================================================================
`include "assert_macros.svh"

module quaternion_nlerp_unit (
  input logic         clk_i,
  input logic         rst_ni,
  qnlerp_in_if.sink   in_i,
  qnlerp_out_if.source out_o
);
  import qnlerp_pkg::*;

  logic adv;

  // stage 1: products
  comp_t a [4];
  comp_t b [4];
  logic [WeightW-1:0] w_sat, w_inv;
  logic signed [ProdW-1:0]  prod_d [4];
  logic signed [BlendW-1:0] pa_d [4];
  logic signed [BlendW-1:0] pb_d [4];
  logic signed [BlendW:0]   pa_wide [4];
  logic signed [BlendW:0]   pb_wide [4];
  logic                     s1_vld_q;
  logic signed [ProdW-1:0]  s1_prod_q [4];
  logic signed [BlendW-1:0] s1_pa_q [4];
  logic signed [BlendW-1:0] s1_pb_q [4];

  // stage 2: dot sign
  logic signed [ProdW+1:0]  dot;
  logic                     s2_vld_q;
  logic                     s2_neg_q;
  logic signed [BlendW-1:0] s2_pa_q [4];
  logic signed [BlendW-1:0] s2_pb_q [4];

  // stage 3: blend, round
  logic signed [BlendW:0]   blend [4];
  logic [BlendW:0]          blend_mag [4];
  logic [BlendW-1:0]        rounded [4];
  logic                     s3_vld_q;
  lanes_t                   s3_q;

  // stage 4, 5: squares and sum
  logic                     s4_vld_q;
  lanes_t                   s4_lanes_q;
  logic [SqW-1:0]           s4_sq_q [4];
  logic                     s5_vld_q;
  lanes_t                   s5_lanes_q;
  logic [SumW-1:0]          s5_sum_q;

  // root and divide chains
  sqrt_stage_t sq_d [SqIter];
  sqrt_stage_t sq_q [SqIter];
  logic        sq_vld_q [SqIter];
  logic [SumW:0] sq_bit [SqIter];
  logic [SumW:0] sq_try [SqIter];
  sqrt_stage_t sq_prev [SqIter];

  logic [RootW-1:0] root;
  div_stage_t dv_d [DivIter+1];
  div_stage_t dv_q [DivIter+1];
  logic       dv_vld_q [DivIter+1];
  logic [NumW:0] dv_sub [DivIter+1][4];

  // output
  logic       out_vld_q;
  comp_t      out_d [4];
  comp_t      out_q [4];
  logic       out_degen_q;

  assign adv = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;

  assign a[0] = in_i.first_x;
  assign a[1] = in_i.first_y;
  assign a[2] = in_i.first_z;
  assign a[3] = in_i.first_w;
  assign b[0] = in_i.second_x;
  assign b[1] = in_i.second_y;
  assign b[2] = in_i.second_z;
  assign b[3] = in_i.second_w;

  assign w_sat = (in_i.blend_weight > WeightOne) ? WeightOne : in_i.blend_weight;
  assign w_inv = WeightOne - w_sat;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod_d[i]  = ProdW'(a[i]) * ProdW'(b[i]);
      pa_wide[i] = (BlendW+1)'(a[i]) * $signed({17'b0, w_inv});
      pb_wide[i] = (BlendW+1)'(b[i]) * $signed({17'b0, w_sat});
      pa_d[i]    = pa_wide[i][BlendW-1:0];
      pb_d[i]    = pb_wide[i][BlendW-1:0];
    end
  end

  assign dot = (ProdW+2)'(s1_prod_q[0]) + (ProdW+2)'(s1_prod_q[1])
             + (ProdW+2)'(s1_prod_q[2]) + (ProdW+2)'(s1_prod_q[3]);

  // negative dot product: flip the second quaternion to take the short arc
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      blend[i]     = s2_neg_q ? ((BlendW+1)'(s2_pa_q[i]) - (BlendW+1)'(s2_pb_q[i]))
                              : ((BlendW+1)'(s2_pa_q[i]) + (BlendW+1)'(s2_pb_q[i]));
      blend_mag[i] = blend[i][BlendW] ? -blend[i] : blend[i];
      rounded[i]   = blend_mag[i][BlendW-1:0] + BlendW'(4);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        s1_prod_q[i] <= prod_d[i];
        s1_pa_q[i]   <= pa_d[i];
        s1_pb_q[i]   <= pb_d[i];
        s2_pa_q[i]   <= s1_pa_q[i];
        s2_pb_q[i]   <= s1_pb_q[i];
        s3_q.mag[i]  <= rounded[i][MagW+2:3];
        s3_q.neg[i]  <= blend[i][BlendW];
        s4_sq_q[i]   <= SqW'(s3_q.mag[i] * s3_q.mag[i]);
      end
      s2_neg_q   <= dot[ProdW+1];
      s4_lanes_q <= s3_q;
      s5_lanes_q <= s4_lanes_q;
      s5_sum_q   <= SumW'(s4_sq_q[0]) + SumW'(s4_sq_q[1])
                  + SumW'(s4_sq_q[2]) + SumW'(s4_sq_q[3]);
    end
  end

  // integer square root, one result bit per stage
  always_comb begin
    for (int k = 0; k < SqIter; k++) begin
      if (k == 0) begin
        sq_prev[k].rem   = (SumW+1)'(s5_sum_q);
        sq_prev[k].root  = '0;
        sq_prev[k].lanes = s5_lanes_q;
      end else begin
        sq_prev[k] = sq_q[k-1];
      end
      sq_bit[k] = (SumW+1)'(1) << (SumW - 1 - 2 * k);
      sq_try[k] = sq_prev[k].root + sq_bit[k];
      sq_d[k]   = sq_prev[k];
      if (sq_prev[k].rem >= sq_try[k]) begin
        sq_d[k].rem  = sq_prev[k].rem - sq_try[k];
        sq_d[k].root = (sq_prev[k].root >> 1) + sq_bit[k];
      end else begin
        sq_d[k].root = sq_prev[k].root >> 1;
      end
    end
  end

  assign root = sq_q[SqIter-1].root[RootW-1:0];

  // divide setup: (mag*32768 + L) / (2L), then one quotient bit per stage
  always_comb begin
    dv_d[0].den   = {root, 1'b0};
    dv_d[0].neg   = sq_q[SqIter-1].lanes.neg;
    dv_d[0].degen = root < DegenLen;
    dv_d[0].quo   = '0;
    for (int i = 0; i < 4; i++) begin
      dv_d[0].rem[i] = (NumW'(sq_q[SqIter-1].lanes.mag[i]) << QuotW) + NumW'(root);
      dv_sub[0][i]   = '0;
    end
    for (int j = 1; j <= DivIter; j++) begin
      dv_d[j] = dv_q[j-1];
      for (int i = 0; i < 4; i++) begin
        dv_sub[j][i] = (NumW+1)'(dv_q[j-1].den) << (DivIter - j);
        if ({1'b0, dv_q[j-1].rem[i]} >= dv_sub[j][i]) begin
          dv_d[j].rem[i] = dv_q[j-1].rem[i] - dv_sub[j][i][NumW-1:0];
          dv_d[j].quo[i][DivIter-j] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (dv_q[DivIter].degen) begin
        out_d[i] = (i == 3) ? QuatOne : QuatZero;
      end else if (dv_q[DivIter].neg[i]) begin
        out_d[i] = -CompW'(dv_q[DivIter].quo[i]);
      end else begin
        out_d[i] = CompW'(dv_q[DivIter].quo[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < SqIter; k++) begin
        sq_q[k] <= sq_d[k];
      end
      for (int j = 0; j <= DivIter; j++) begin
        dv_q[j] <= dv_d[j];
      end
      for (int i = 0; i < 4; i++) begin
        out_q[i] <= out_d[i];
      end
      out_degen_q <= dv_q[DivIter].degen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      for (int k = 0; k < SqIter; k++) begin
        sq_vld_q[k] <= 1'b0;
      end
      for (int j = 0; j <= DivIter; j++) begin
        dv_vld_q[j] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_i.valid;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      sq_vld_q[0] <= s5_vld_q;
      for (int k = 1; k < SqIter; k++) begin
        sq_vld_q[k] <= sq_vld_q[k-1];
      end
      dv_vld_q[0] <= sq_vld_q[SqIter-1];
      for (int j = 1; j <= DivIter; j++) begin
        dv_vld_q[j] <= dv_vld_q[j-1];
      end
      out_vld_q <= dv_vld_q[DivIter];
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.out_x      = out_q[0];
  assign out_o.out_y      = out_q[1];
  assign out_o.out_z      = out_q[2];
  assign out_o.out_w      = out_q[3];
  assign out_o.degenerate = out_degen_q;

  // quotient must fit: component magnitude never exceeds the length
  `QN_ASSERT(quot_fits_a, clk_i, rst_ni, dv_vld_q[0] && !dv_q[0].degen |-> (dv_q[0].rem[0] >> QuotW) < NumW'(dv_q[0].den) && (dv_q[0].rem[3] >> QuotW) < NumW'(dv_q[0].den))
  `QN_ASSERT(out_range_a, clk_i, rst_ni, out_vld_q |-> out_q[0] <= QuatOne && out_q[0] >= -QuatOne && out_q[3] <= QuatOne && out_q[3] >= -QuatOne)
  `QN_ASSERT_ALWAYS(degen_ident_a, clk_i, out_vld_q && out_degen_q |-> out_q[3] == QuatOne && out_q[0] == QuatZero)

endmodule
